// ===== src/psat_pkg.sv =====
// shared types, constants and codes of the per-thread socket admission table
// no dependencies; every other file of the block imports this package

package psat_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam int MODE_W   = 3;
   localparam int THREAD_W = 22;
   localparam int ACTIVE_W = 16;
   localparam int COUNT_W  = 32;
   localparam int LIMIT_W  = 16;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [MODE_W-1:0] MODE_CHECK   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REG     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_UNREG   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TRAFFIC = 3'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NONE_OPEN = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SOCKET_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PENDING_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENFORCE       = 2'd2;

   localparam logic [LIMIT_W-1:0] SOCKET_LIMIT_RESET  = 16'd10;
   localparam logic [LIMIT_W-1:0] PENDING_LIMIT_RESET = 16'd5;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [THREAD_W-1:0] thread_id;
      logic [COUNT_W-1:0]  bytes_out;
      logic [COUNT_W-1:0]  bytes_in;
      logic [COUNT_W-1:0]  time_now;
   } req_type;

   typedef struct packed {
      logic                admitted;
      logic [STATUS_W-1:0] status;
      logic [ACTIVE_W-1:0] active_now;
      logic [COUNT_W-1:0]  refusals;
      logic [COUNT_W-1:0]  sent_sum;
      logic [COUNT_W-1:0]  received_sum;
      logic [COUNT_W-1:0]  last_refusal_time;
   } rsp_type;

   typedef struct packed {
      logic [THREAD_W-1:0] thread;
      logic [ACTIVE_W-1:0] active;
      logic [COUNT_W-1:0]  sent;
      logic [COUNT_W-1:0]  received;
      logic [COUNT_W-1:0]  refusals;
      logic [COUNT_W-1:0]  refusal_time;
   } entry_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic last;
      logic out_busy;
   } stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

endpackage

// ===== src/psat_ctrl.sv =====
// controller of the admission table: idle, table scan and commit sequencing
// depends on psat_pkg; drives commands into psat_dp and reads its status

module psat_ctrl
   import psat_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.match || stat.last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!stat.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = !stat.out_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== src/psat_dp.sv =====
// datapath of the admission table: entry storage, scan registers, update and
// result register; depends on psat_pkg, sequenced by psat_ctrl

module psat_dp
   import psat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  cmd_type               cmd,
   output stat_type              stat
);

   logic [LIMIT_W-1:0] socket_limit_ff;
   logic [LIMIT_W-1:0] pending_limit_ff;
   logic               enforce_ff;

   logic      valid_ff [TABLE_ENTRIES];
   entry_type entry_ff [TABLE_ENTRIES];

   req_type          req_ff;
   logic [IDX_W-1:0] scan_idx_ff;
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   entry_type        hit_entry_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic      claim_mode;
   logic      claim;
   logic      use_slot;
   logic [IDX_W-1:0] slot_idx;
   entry_type cur;
   entry_type nxt;
   rsp_type   rsp_in;
   logic      scan_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         socket_limit_ff  <= SOCKET_LIMIT_RESET;
         pending_limit_ff <= PENDING_LIMIT_RESET;
         enforce_ff       <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SOCKET_LIMIT:  socket_limit_ff  <= csr_wdata;
            CSR_PENDING_LIMIT: pending_limit_ff <= csr_wdata;
            CSR_ENFORCE:       enforce_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // scan compare on the current index
   assign scan_valid = valid_ff[scan_idx_ff];
   assign stat.match = scan_valid && (entry_ff[scan_idx_ff].thread == req_ff.thread_id);
   assign stat.last  = (scan_idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign stat.out_busy = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.step && stat.match) begin
         hit_entry_ff <= entry_ff[scan_idx_ff];
         hit_idx_ff   <= scan_idx_ff;
      end
      if (cmd.step && !scan_valid && !free_found_ff) begin
         free_idx_ff <= scan_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff   <= '0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.load) begin
         scan_idx_ff   <= '0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.step) begin
         if (!stat.last) scan_idx_ff <= scan_idx_ff + 1'b1;
         if (stat.match) hit_ff <= 1'b1;
         if (!scan_valid) free_found_ff <= 1'b1;
      end
   end

   // entry update for the request
   always_comb begin
      claim_mode = ((req_ff.mode == MODE_CHECK) && enforce_ff) ||
                   (req_ff.mode == MODE_REG) || (req_ff.mode == MODE_TRAFFIC);
      claim      = !hit_ff && claim_mode && free_found_ff;
      use_slot   = hit_ff || claim;
      slot_idx   = hit_ff ? hit_idx_ff : free_idx_ff;
      if (claim) begin
         cur        = '0;
         cur.thread = req_ff.thread_id;
      end else begin
         cur = hit_entry_ff;
      end
      nxt    = cur;
      rsp_in = '0;
      case (req_ff.mode)
         MODE_CHECK: begin
            if (!enforce_ff) begin
               rsp_in.admitted = 1'b1;
            end else if (!use_slot) begin
               rsp_in.admitted = 1'b1;
               rsp_in.status   = STATUS_FULL;
            end else if ((cur.active >= socket_limit_ff) || (pending_limit_ff == '0)) begin
               nxt.refusals     = cur.refusals + 1'b1;
               nxt.refusal_time = req_ff.time_now;
            end else begin
               rsp_in.admitted = 1'b1;
            end
         end
         MODE_REG: begin
            if (!use_slot) begin
               rsp_in.status = STATUS_FULL;
            end else if (cur.active != '1) begin
               nxt.active = cur.active + 1'b1;
            end
         end
         MODE_UNREG: begin
            if (!hit_ff) begin
               rsp_in.status = STATUS_NOT_FOUND;
            end else if (cur.active != '0) begin
               nxt.active = cur.active - 1'b1;
            end else begin
               rsp_in.status = STATUS_NONE_OPEN;
            end
         end
         MODE_TRAFFIC: begin
            if (!use_slot) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               nxt.sent     = cur.sent + req_ff.bytes_out;
               nxt.received = cur.received + req_ff.bytes_in;
            end
         end
         default: begin
            if (!hit_ff) rsp_in.status = STATUS_NOT_FOUND;
         end
      endcase
      if (use_slot) begin
         rsp_in.active_now        = nxt.active;
         rsp_in.refusals          = nxt.refusals;
         rsp_in.sent_sum          = nxt.sent;
         rsp_in.received_sum      = nxt.received;
         rsp_in.last_refusal_time = nxt.refusal_time;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && use_slot) begin
         entry_ff[slot_idx] <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (cmd.commit && use_slot) begin
         valid_ff[slot_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/per_thread_socket_admission_table.sv =====
// top level of the per-thread socket admission table
// depends on psat_pkg, psat_ctrl and psat_dp
//
// usage:
//   req channel (req_valid/req_ready/req_data) carries one request word:
//   mode, thread id, byte counts and the current time. rsp channel
//   (rsp_valid/rsp_ready/rsp_data) returns one result word per request.
//   csr port writes socket_limit (0), pending_limit (1) and enforce_enable
//   (2) on any cycle with csr_we high; other indexes are dropped.
// timing:
//   a request is scanned against the 16 entries, one entry per cycle, and
//   the scan stops at the matching entry or at the last entry. the result
//   word is registered at commit. a request is accepted only in idle, so
//   the block takes no new request until the last one has been committed.
//   the entry scan goes through a single compare on the current index.
// reset: synchronous, marks all entries invalid and loads limits 10 and 5 with
//   enforcement on. no clearing pass is needed.
// stall: the result register holds while rsp_ready is low; the next
//   request is still accepted and scanned, and waits at commit until the
//   pending result is taken.

module per_thread_socket_admission_table
   import psat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   psat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   psat_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ===== src/psat_checker.sv =====
// port-level checks of the admission table and the bind that attaches them
// depends on psat_pkg and per_thread_socket_admission_table

module psat_checker
   import psat_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // one request in flight: scan starts right after acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted during scan");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result word changed");

   // no entry involved means empty slot fields and no refusal
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_data.status == STATUS_FULL) ||
                     (rsp_data.status == STATUS_NOT_FOUND))) |->
      ((rsp_data.active_now == '0) && (rsp_data.refusals == '0) &&
       (rsp_data.last_refusal_time == '0) &&
       ((rsp_data.status == STATUS_FULL) || !rsp_data.admitted)))
      else $error("slot fields set without an entry");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

endmodule

bind per_thread_socket_admission_table psat_checker u_psat_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for the per-thread socket admission table: directed and random
// request words, each result predicted at acceptance and checked in order by a scoreboard
// depends on psat_pkg and per_thread_socket_admission_table

import psat_pkg::*;

class admission_book;
   logic [LIMIT_W-1:0] socket_limit;
   logic [LIMIT_W-1:0] pending_limit;
   logic               enforce;
   bit                 in_use[TABLE_ENTRIES];
   entry_type          slot[TABLE_ENTRIES];
   rsp_type            expected_outcomes[$];
   int mismatches;
   int results_seen;
   int words_seen;
   int refused_checks;
   int full_hits;
   int unknown_hits;
   int empty_unregs;
   int saturations;

   function new();
      socket_limit  = SOCKET_LIMIT_RESET;
      pending_limit = PENDING_LIMIT_RESET;
      enforce       = 1'b1;
      foreach (in_use[i]) in_use[i] = 1'b0;
   endfunction

   function void set_register(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_SOCKET_LIMIT:  socket_limit = val;
         CSR_PENDING_LIMIT: pending_limit = val;
         CSR_ENFORCE:       enforce = val[0];
         default: ;
      endcase
   endfunction

   function int find_slot(input logic [THREAD_W-1:0] tid);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (in_use[i] && slot[i].thread == tid) return i;
      return -1;
   endfunction

   function int claim_slot(input logic [THREAD_W-1:0] tid);
      int s;
      s = find_slot(tid);
      if (s >= 0) return s;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (!in_use[i]) begin
            in_use[i] = 1'b1;
            slot[i] = '0;
            slot[i].thread = tid;
            return i;
         end
      end
      return -1;
   endfunction

   function void note_request(input req_type w);
      rsp_type o;
      int s;
      o = '0;
      s = -1;
      words_seen++;
      case (w.mode)
         MODE_CHECK: begin
            if (!enforce) begin
               o.admitted = 1'b1;
               s = find_slot(w.thread_id);
            end else begin
               s = claim_slot(w.thread_id);
               if (s < 0) begin
                  o.admitted = 1'b1;
                  o.status = STATUS_FULL;
               end else if (slot[s].active >= socket_limit || pending_limit == '0) begin
                  slot[s].refusals = slot[s].refusals + 1;
                  slot[s].refusal_time = w.time_now;
                  refused_checks++;
               end else begin
                  o.admitted = 1'b1;
               end
            end
         end
         MODE_REG: begin
            s = claim_slot(w.thread_id);
            if (s < 0) begin
               o.status = STATUS_FULL;
            end else if (slot[s].active != '1) begin
               slot[s].active = slot[s].active + 1;
            end else begin
               saturations++;
            end
         end
         MODE_UNREG: begin
            s = find_slot(w.thread_id);
            if (s < 0) begin
               o.status = STATUS_NOT_FOUND;
            end else if (slot[s].active != '0) begin
               slot[s].active = slot[s].active - 1;
            end else begin
               o.status = STATUS_NONE_OPEN;
            end
         end
         MODE_TRAFFIC: begin
            s = claim_slot(w.thread_id);
            if (s < 0) begin
               o.status = STATUS_FULL;
            end else begin
               slot[s].sent = slot[s].sent + w.bytes_out;
               slot[s].received = slot[s].received + w.bytes_in;
            end
         end
         default: begin
            s = find_slot(w.thread_id);
            if (s < 0) o.status = STATUS_NOT_FOUND;
         end
      endcase
      if (s >= 0) begin
         o.active_now = slot[s].active;
         o.refusals = slot[s].refusals;
         o.sent_sum = slot[s].sent;
         o.received_sum = slot[s].received;
         o.last_refusal_time = slot[s].refusal_time;
      end
      case (o.status)
         STATUS_FULL:      full_hits++;
         STATUS_NOT_FOUND: unknown_hits++;
         STATUS_NONE_OPEN: empty_unregs++;
         default: ;
      endcase
      expected_outcomes.push_back(o);
   endfunction

   function void check_result(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (expected_outcomes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d arrived with nothing expected: %p", results_seen, got);
         return;
      end
      want = expected_outcomes.pop_front();
      if (got.admitted !== want.admitted || got.status !== want.status ||
          got.active_now !== want.active_now || got.refusals !== want.refusals ||
          got.sent_sum !== want.sent_sum || got.received_sum !== want.received_sum ||
          got.last_refusal_time !== want.last_refusal_time) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("result %0d mismatch: expected adm=%0d st=%0d act=%0d ref=%0d %h %h %h",
                     results_seen, want.admitted, want.status, want.active_now,
                     want.refusals, want.sent_sum, want.received_sum, want.last_refusal_time);
            $display("                      actual adm=%0d st=%0d act=%0d ref=%0d %h %h %h",
                     got.admitted, got.status, got.active_now, got.refusals,
                     got.sent_sum, got.received_sum, got.last_refusal_time);
         end
      end
   endfunction

   function int outstanding();
      return expected_outcomes.size();
   endfunction
endclass

module tb_top;
   localparam logic [MODE_W-1:0]    MODE_QUERY       = 3'd4;
   localparam logic [MODE_W-1:0]    MODE_ALIAS_FIRST = 3'd5;
   localparam logic [MODE_W-1:0]    MODE_ALIAS_LAST  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE        = 2'd3;
   localparam logic [THREAD_W-1:0]  THREAD_TOP       = '1;
   localparam int POOL_SIZE       = 24;
   localparam int PHASE_WORDS     = 285;
   localparam int LONG_HOLD       = 300;
   localparam int SETTLE_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int REG_BURST_WORDS = 24;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   admission_book book;
   logic [THREAD_W-1:0] thread_pool[POOL_SIZE];
   int rsp_stall_pct = 0;
   int req_gap_pct = 0;
   int holds_asked = 0;
   int holds_done = 0;
   int idle_cycles = 0;

   always #10 clock = ~clock;

   per_thread_socket_admission_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [COUNT_W-1:0] pick_bytes();
      return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1500);
   endfunction

   function automatic req_type make_word(input logic [MODE_W-1:0]   m,
                                         input logic [THREAD_W-1:0] t,
                                         input logic [COUNT_W-1:0]  bo,
                                         input logic [COUNT_W-1:0]  bi,
                                         input logic [COUNT_W-1:0]  now);
      req_type w;
      w.mode = m;
      w.thread_id = t;
      w.bytes_out = bo;
      w.bytes_in = bi;
      w.time_now = now;
      return w;
   endfunction

   function automatic req_type random_word();
      logic [MODE_W-1:0]   m;
      logic [THREAD_W-1:0] t;
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) m = MODE_CHECK;
      else if (r < 55) m = MODE_REG;
      else if (r < 75) m = MODE_UNREG;
      else if (r < 88) m = MODE_TRAFFIC;
      else if (r < 96) m = MODE_QUERY;
      else m = MODE_W'($urandom_range(MODE_ALIAS_FIRST, MODE_ALIAS_LAST));
      // mostly a fixed set of threads so entries get reused, some strangers
      if ($urandom_range(0, 6) == 0) t = THREAD_W'($urandom);
      else t = thread_pool[$urandom_range(0, POOL_SIZE - 1)];
      return make_word(m, t, pick_bytes(), pick_bytes(), $urandom);
   endfunction

   task automatic send_word(input req_type w);
      int gap;
      gap = ($urandom_range(0, 99) < req_gap_pct) ? gap_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_request(w);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      book.set_register(idx, val);
   endtask

   task automatic run_phase(input logic [LIMIT_W-1:0] sock,
                            input logic [LIMIT_W-1:0] pend,
                            input logic on,
                            input int idle_pct,
                            input int hold_at,
                            input int pause_at);
      int i;
      drain();
      write_csr(CSR_SOCKET_LIMIT, sock);
      write_csr(CSR_PENDING_LIMIT, pend);
      write_csr(CSR_ENFORCE, {{(CSR_DATA_W - 1){1'b0}}, on});
      rsp_stall_pct = idle_pct;
      req_gap_pct = idle_pct;
      for (i = 0; i < PHASE_WORDS; i++) begin
         if (i == hold_at) holds_asked++;
         if (i == pause_at) drain();
         send_word(random_word());
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) book.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
   end

   initial begin : rsp_side
      int len;
      forever begin
         @(negedge clock);
         if (holds_asked != holds_done) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            len = gap_len();
            rsp_ready <= 1'b0;
            repeat (len) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int n;
      book = new();
      foreach (thread_pool[i]) thread_pool[i] = THREAD_W'($urandom);
      thread_pool[0] = '0;
      thread_pool[1] = THREAD_TOP;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // unused index must not land on any register
      write_csr(CSR_SPARE, '0);
      send_word(make_word(MODE_QUERY, '0, '0, '0, '0));
      send_word(make_word(MODE_UNREG, '0, '1, '1, '1));
      send_word(make_word(MODE_TRAFFIC, '0, '1, '1, '0));
      send_word(make_word(MODE_TRAFFIC, '0, 32'd1, 32'd2, '1));
      send_word(make_word(MODE_CHECK, '0, '0, '0, '1));
      send_word(make_word(MODE_UNREG, '0, '0, '0, '0));
      send_word(make_word(MODE_REG, THREAD_TOP, '1, '0, '1));
      send_word(make_word(MODE_UNREG, THREAD_TOP, '0, '1, '0));
      for (n = MODE_ALIAS_FIRST; n <= MODE_ALIAS_LAST; n++)
         send_word(make_word(MODE_W'(n), THREAD_TOP, $urandom, $urandom, $urandom));
      send_word(make_word(MODE_QUERY, THREAD_TOP, '1, '1, '1));

      // zero pending limit refuses every check
      drain();
      write_csr(CSR_PENDING_LIMIT, '0);
      send_word(make_word(MODE_CHECK, '0, '0, '0, 32'hAAAA_AAAA));
      send_word(make_word(MODE_CHECK, '0, '0, '0, 32'h5555_5555));

      drain();
      write_csr(CSR_SOCKET_LIMIT, '0);
      write_csr(CSR_PENDING_LIMIT, PENDING_LIMIT_RESET);
      send_word(make_word(MODE_CHECK, THREAD_TOP, '0, '0, 32'h1234_5678));

      // enforcement off: admit without creating entries
      drain();
      write_csr(CSR_ENFORCE, '0);
      send_word(make_word(MODE_CHECK, 22'h2A_AAAA, '0, '0, '1));
      send_word(make_word(MODE_CHECK, '0, '0, '0, '1));
      send_word(make_word(MODE_QUERY, 22'h2A_AAAA, '0, '0, '0));

      // raise the active count of entry 0 past the socket limit
      drain();
      write_csr(CSR_ENFORCE, 16'd1);
      write_csr(CSR_SOCKET_LIMIT, SOCKET_LIMIT_RESET);
      for (n = 0; n < REG_BURST_WORDS; n++)
         send_word(make_word(MODE_REG, '0, n, ~n, n));
      send_word(make_word(MODE_UNREG, '0, '0, '0, '0));
      send_word(make_word(MODE_REG, '0, '0, '0, '0));

      run_phase(16'd3, 16'd5, 1'b1, 0, -1, -1);
      run_phase('0, '1, 1'b1, 25, -1, -1);
      run_phase('1, 16'd1, 1'b1, 25, 100, -1);
      run_phase(LIMIT_W'($urandom_range(0, 6)), '0, 1'b1, 25, -1, 150);
      run_phase(LIMIT_W'($urandom_range(1, 8)), LIMIT_W'($urandom_range(1, 65535)),
                1'b0, 25, -1, -1);
      run_phase(LIMIT_W'($urandom_range(0, 8)), LIMIT_W'($urandom), 1'b1, 25, 60, -1);
      drain();

      $display("%0d request words, %0d result words checked, %0d mismatches",
               book.words_seen, book.results_seen, book.mismatches);
      $display("seen: %0d refused checks, %0d table full, %0d unknown thread, %0d %s %0d %s",
               book.refused_checks, book.full_hits, book.unknown_hits, book.empty_unregs,
               "unregisters at zero,", book.saturations, "saturated registers");
      if (book.mismatches == 0 && book.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
